// ===== design/pesev_pkg.sv =====
// ----------------------------------------------------------------------------
// pesev_pkg
// Shared types and constants of the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
package pesev_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = 6;
  localparam int STATUS_W    = 3;
  localparam int SYM_W       = 8;
  localparam int OUT_FLD_W   = DATA_W + DEPTH_W + STATUS_W;
  localparam int OUT_W       = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BADCHAR = 3'd1,
    ST_UNDER   = 3'd2,
    ST_OVER    = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

  function automatic op_t decode_sym(input logic [SYM_W-1:0] sym);
    op_t op;
    unique case (sym) inside
      [CH_ZERO:CH_NINE]: op = OP_DIGIT;
      CH_PLUS:           op = OP_ADD;
      CH_MINUS:          op = OP_SUB;
      CH_STAR:           op = OP_MUL;
      CH_SLASH:          op = OP_DIV;
      default:           op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ===== design/pesev_ram.sv =====
// ----------------------------------------------------------------------------
// pesev_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pesev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/pesev_div.sv =====
// ----------------------------------------------------------------------------
// pesev_div
// Signed 32-bit divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pesev_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pesev_pkg::div_req_t req,
  output pesev_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(pesev_pkg::DATA_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic                         neg_r, neg_nxt;
  logic [pesev_pkg::DATA_W-1:0] den_r, den_nxt;
  logic [pesev_pkg::DATA_W-1:0] rem_r, rem_nxt;
  logic [pesev_pkg::DATA_W-1:0] quo_r, quo_nxt;
  logic [pesev_pkg::DATA_W:0]   shifted;
  logic [pesev_pkg::DATA_W+1:0] diff;
  logic                         a_neg, b_neg;

  assign a_neg   = req.dividend[pesev_pkg::DATA_W-1];
  assign b_neg   = req.divisor[pesev_pkg::DATA_W-1];
  // The remainder stays below the divisor, so one extra bit holds the shift.
  assign shifted = {rem_r, quo_r[pesev_pkg::DATA_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = a_neg ^ b_neg;
      den_nxt  = b_neg ? (~req.divisor + 1'b1) : req.divisor;
      quo_nxt  = a_neg ? (~req.dividend + 1'b1) : req.dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!diff[pesev_pkg::DATA_W+1]) begin
        rem_nxt = diff[pesev_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[pesev_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[pesev_pkg::DATA_W-1:0];
        quo_nxt = {quo_r[pesev_pkg::DATA_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(pesev_pkg::DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== design/prefix_expression_stack_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_stack_evaluator_unit
// Evaluates a prefix expression fed from its last character to its first.
// ----------------------------------------------------------------------------
// One beat in carries a character and a start flag; one beat out carries the
// top of stack, the depth and a status. Operands live in a 32-entry RAM with a
// registered read, and the top of stack is also kept in a register.
// Digits, bad characters and operators refused for underflow go from idle
// straight to the done state, and a divide by zero passes through execute;
// '+', '-' and '*' go through execute, for the RAM read of the second operand,
// and then write-back; '/' waits between the two for the 32-step
// shift-subtract divider. A finished result waits in the output register, and
// the next beat is taken while it waits.
module prefix_expression_stack_evaluator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [pesev_pkg::SYM_W-1:0] in_tdata,   // [7:0] symbol
  input  logic [0:0]                  in_tuser,   // [0] start_req
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [pesev_pkg::OUT_W-1:0] out_tdata   // [31:0] top_value,
                                                  // [37:32] depth,
                                                  // [40:38] status
);

  localparam int CNT_W  = pesev_pkg::CNT_W;
  localparam int ADDR_W = pesev_pkg::ADDR_W;
  localparam int DATA_W = pesev_pkg::DATA_W;

  pesev_pkg::state_t  state_r, state_nxt;
  pesev_pkg::op_t     op_r, op_nxt;
  pesev_pkg::status_t status_r, status_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  top_r, top_nxt;
  logic [DATA_W-1:0]  res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [pesev_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic               in_acc;
  logic               out_free;
  logic [CNT_W-1:0]   cnt_eff;
  pesev_pkg::op_t     sym_op;
  logic               ram_wr_en;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0]  ram_wr_data;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0]  ram_rd_data;
  logic [DATA_W-1:0]  top_shown;
  pesev_pkg::div_req_t div_req;
  pesev_pkg::div_rsp_t div_rsp;

  assign in_tready = (state_r == pesev_pkg::S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;
  assign cnt_eff   = in_tuser[0] ? '0 : count_r;
  assign sym_op    = pesev_pkg::decode_sym(in_tdata);
  assign top_shown = (count_r != '0) ? top_r : '0;

  pesev_ram #(
    .WIDTH (DATA_W),
    .DEPTH (pesev_pkg::STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  pesev_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pesev_pkg::S_IDLE: begin
        if (in_acc) begin
          if ((sym_op == pesev_pkg::OP_ADD || sym_op == pesev_pkg::OP_SUB ||
               sym_op == pesev_pkg::OP_MUL || sym_op == pesev_pkg::OP_DIV) &&
              (cnt_eff >= CNT_W'(2))) begin
            state_nxt = pesev_pkg::S_EXEC;
          end else begin
            state_nxt = pesev_pkg::S_DONE;
          end
        end
      end
      pesev_pkg::S_EXEC: begin
        if (op_r == pesev_pkg::OP_DIV) begin
          state_nxt = (ram_rd_data == '0) ? pesev_pkg::S_DONE : pesev_pkg::S_DIV;
        end else begin
          state_nxt = pesev_pkg::S_WRITE;
        end
      end
      pesev_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = pesev_pkg::S_WRITE;
        end
      end
      pesev_pkg::S_WRITE: state_nxt = pesev_pkg::S_DONE;
      pesev_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = pesev_pkg::S_IDLE;
        end
      end
      default: state_nxt = pesev_pkg::S_IDLE;
    endcase
  end

  // Datapath, RAM and divider control.
  always_comb begin
    op_nxt        = op_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    top_nxt       = top_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = ADDR_W'(count_r - CNT_W'(2));
    ram_wr_data   = res_r;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = ADDR_W'(cnt_eff - CNT_W'(2));
    div_req.start    = 1'b0;
    div_req.dividend = top_r;
    div_req.divisor  = ram_rd_data;
    unique case (state_r)
      pesev_pkg::S_IDLE: begin
        if (in_acc) begin
          op_nxt     = sym_op;
          status_nxt = pesev_pkg::ST_OK;
          count_nxt  = cnt_eff;
          case (sym_op)
            pesev_pkg::OP_DIGIT: begin
              if (cnt_eff >= CNT_W'(pesev_pkg::STACK_DEPTH)) begin
                status_nxt = pesev_pkg::ST_OVER;
              end else begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = ADDR_W'(cnt_eff);
                ram_wr_data = DATA_W'(in_tdata - pesev_pkg::CH_ZERO);
                top_nxt     = DATA_W'(in_tdata - pesev_pkg::CH_ZERO);
                count_nxt   = cnt_eff + 1'b1;
              end
            end
            pesev_pkg::OP_NONE: status_nxt = pesev_pkg::ST_BADCHAR;
            default: begin
              // The left operand is the cached top; fetch the right one.
              if (cnt_eff < CNT_W'(2)) begin
                status_nxt = pesev_pkg::ST_UNDER;
              end else begin
                ram_rd_en = 1'b1;
              end
            end
          endcase
        end
      end
      pesev_pkg::S_EXEC: begin
        case (op_r)
          pesev_pkg::OP_ADD: res_nxt = top_r + ram_rd_data;
          pesev_pkg::OP_SUB: res_nxt = top_r - ram_rd_data;
          pesev_pkg::OP_MUL: res_nxt = DATA_W'(top_r * ram_rd_data);
          pesev_pkg::OP_DIV: begin
            if (ram_rd_data == '0) begin
              status_nxt = pesev_pkg::ST_DIVZERO;
            end else begin
              div_req.start = 1'b1;
            end
          end
          default: res_nxt = res_r;
        endcase
      end
      pesev_pkg::S_DIV: begin
        if (div_rsp.done) begin
          res_nxt = div_rsp.quot;
        end
      end
      pesev_pkg::S_WRITE: begin
        ram_wr_en = 1'b1;
        top_nxt   = res_r;
        count_nxt = count_r - 1'b1;
      end
      pesev_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = pesev_pkg::OUT_W'({status_r,
                                             pesev_pkg::DEPTH_W'(count_r),
                                             top_shown});
        end
      end
      default: begin
        op_nxt = op_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pesev_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    top_r      <= top_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(pesev_pkg::STACK_DEPTH))
    else $error("stack count above stack depth");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == pesev_pkg::S_EXEC || state_r == pesev_pkg::S_DONE))
    else $error("accepted beat did not start processing");

  a_div_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (state_r == pesev_pkg::S_EXEC && op_r == pesev_pkg::OP_DIV))
    else $error("divider started outside a divide");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == pesev_pkg::S_DIV))
    else $error("divider finished while not awaited");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the prefix expression stack evaluator.
// ----------------------------------------------------------------------------
// Characters go in as stream beats with a start flag in tuser. The bench keeps
// its own operand stack and predicts the top of stack, depth and status of
// every accepted beat. Each result beat is compared field by field with the
// oldest prediction. The stimulus is a short hand-picked opening, then random
// well-formed expressions, deep pushes, noise and damaged expressions. Both
// sides pause at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic                        start;
    logic [pesev_pkg::SYM_W-1:0] sym;
    int                          gap;
  } char_beat_t;

  typedef struct packed {
    logic [pesev_pkg::DATA_W-1:0]  top;
    logic [pesev_pkg::DEPTH_W-1:0] depth;
    pesev_pkg::status_t            status;
  } stack_view_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [pesev_pkg::SYM_W-1:0] in_tdata   = '0;
  logic [0:0]                  in_tuser   = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [pesev_pkg::OUT_W-1:0] out_tdata;

  char_beat_t  char_queue[$];
  stack_view_t predicted_views[$];

  logic [pesev_pkg::DATA_W-1:0] model_stack [pesev_pkg::STACK_DEPTH];
  int                           model_count = 0;

  logic in_taken = 1'b0;
  logic hold_off = 1'b0;
  bit   gen_calm = 1'b0;
  int   rx_stall = 0;
  int   rx_calm  = 0;
  int   chars_in = 0;
  int   views_checked = 0;
  int   err_count = 0;
  int   status_hits [5] = '{default: 0};

  prefix_expression_stack_evaluator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Operands are popped left first, so the left operand is the top entry.
  function automatic stack_view_t apply_symbol(input logic clear,
                                               input logic [pesev_pkg::SYM_W-1:0] sym);
    stack_view_t                  v;
    pesev_pkg::op_t               op;
    logic [pesev_pkg::DATA_W-1:0] lhs, rhs, res, mag_l, mag_r, quo;
    v.status = pesev_pkg::ST_OK;
    res = '0;
    if (clear) model_count = 0;
    if (sym >= pesev_pkg::CH_ZERO && sym <= pesev_pkg::CH_NINE) op = pesev_pkg::OP_DIGIT;
    else if (sym == pesev_pkg::CH_PLUS) op = pesev_pkg::OP_ADD;
    else if (sym == pesev_pkg::CH_MINUS) op = pesev_pkg::OP_SUB;
    else if (sym == pesev_pkg::CH_STAR) op = pesev_pkg::OP_MUL;
    else if (sym == pesev_pkg::CH_SLASH) op = pesev_pkg::OP_DIV;
    else op = pesev_pkg::OP_NONE;
    case (op)
      pesev_pkg::OP_DIGIT: begin
        if (model_count >= pesev_pkg::STACK_DEPTH) begin
          v.status = pesev_pkg::ST_OVER;
        end else begin
          model_stack[model_count] = pesev_pkg::DATA_W'(sym - pesev_pkg::CH_ZERO);
          model_count++;
        end
      end
      pesev_pkg::OP_NONE: begin
        v.status = pesev_pkg::ST_BADCHAR;
      end
      default: begin
        if (model_count < 2) begin
          v.status = pesev_pkg::ST_UNDER;
        end else begin
          lhs = model_stack[model_count-1];
          rhs = model_stack[model_count-2];
          case (op)
            pesev_pkg::OP_ADD: res = lhs + rhs;
            pesev_pkg::OP_SUB: res = lhs - rhs;
            pesev_pkg::OP_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                v.status = pesev_pkg::ST_DIVZERO;
              end else begin
                // Divide magnitudes, then fix the sign: truncation toward zero.
                mag_l = lhs[pesev_pkg::DATA_W-1] ? -lhs : lhs;
                mag_r = rhs[pesev_pkg::DATA_W-1] ? -rhs : rhs;
                quo   = mag_l / mag_r;
                res   = (lhs[pesev_pkg::DATA_W-1] ^ rhs[pesev_pkg::DATA_W-1]) ? -quo : quo;
              end
            end
          endcase
          if (v.status == pesev_pkg::ST_OK) begin
            model_count--;
            model_stack[model_count-1] = res;
          end
        end
      end
    endcase
    v.top   = (model_count > 0) ? model_stack[model_count-1] : '0;
    v.depth = pesev_pkg::DEPTH_W'(model_count);
    return v;
  endfunction

  function automatic int pick_idle(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [pesev_pkg::SYM_W-1:0] rand_digit();
    return pesev_pkg::CH_ZERO + pesev_pkg::SYM_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [pesev_pkg::SYM_W-1:0] rand_operator();
    case ($urandom_range(0, 3))
      0:       return pesev_pkg::CH_PLUS;
      1:       return pesev_pkg::CH_MINUS;
      2:       return pesev_pkg::CH_STAR;
      default: return pesev_pkg::CH_SLASH;
    endcase
  endfunction

  task automatic queue_char(input logic start, input logic [pesev_pkg::SYM_W-1:0] sym);
    char_beat_t b;
    b.start = start;
    b.sym   = sym;
    b.gap   = pick_idle(gen_calm);
    char_queue.push_back(b);
  endtask

  task automatic queue_noise();
    queue_char($urandom_range(0, 7) == 0, pesev_pkg::SYM_W'($urandom_range(0, 255)));
  endtask

  // Emits an expression in arrival order (prefix text read right to left).
  // The stack holds at most max_held operands; damaged ones get noise or stray operators mixed in.
  task automatic queue_expression(input int max_held, input int n_ops, input bit damaged);
    int held;
    int ops_done;
    bit first;
    held = 0;
    ops_done = 0;
    first = 1'b1;
    gen_calm = ($urandom_range(0, 4) == 0);
    while (ops_done < n_ops || held != 1) begin
      if (held < 2 || (held < max_held && ops_done < n_ops && $urandom_range(0, 1))) begin
        queue_char(first && ($urandom_range(0, 3) != 0), rand_digit());
        held++;
      end else begin
        queue_char(first && ($urandom_range(0, 3) != 0), rand_operator());
        held--;
        ops_done++;
      end
      first = 1'b0;
      if (damaged && $urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 1)) queue_noise();
        else queue_char(1'b0, rand_operator());
      end
    end
  endtask

  task automatic report_mismatch(input string field,
                                 input logic [pesev_pkg::DATA_W-1:0] got,
                                 input logic [pesev_pkg::DATA_W-1:0] want);
    err_count++;
    $display("%0t: result %0d mismatch on %s: got 0x%08h, expected 0x%08h",
             $realtime, views_checked, field, got, want);
  endtask

  // Input driver: holds a beat until it is taken, then pauses as the next beat asks.
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (char_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (char_queue[0].gap > 0) begin
        char_queue[0].gap = char_queue[0].gap - 1;
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= char_queue[0].sym;
        in_tuser  <= char_queue[0].start;
        void'(char_queue.pop_front());
      end
    end
  end

  // Result receiver with random stalls and calm stretches.
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      out_tready <= 1'b1;
      if (rx_calm > 0) rx_calm--;
      else if ($urandom_range(0, 99) < 3) rx_calm = $urandom_range(40, 150);
      else if ($urandom_range(0, 3) == 0) rx_stall = pick_idle(1'b0);
    end
  end

  // Monitor: checks result beats, then predicts from the accepted input beat.
  always @(posedge clk) begin
    stack_view_t want;
    stack_view_t got;
    in_taken <= in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.top    = out_tdata[pesev_pkg::DATA_W-1:0];
      got.depth  = out_tdata[pesev_pkg::DATA_W +: pesev_pkg::DEPTH_W];
      got.status = pesev_pkg::status_t'(
                     out_tdata[pesev_pkg::DATA_W+pesev_pkg::DEPTH_W +: pesev_pkg::STATUS_W]);
      if (predicted_views.size() == 0) begin
        report_mismatch("unexpected beat", pesev_pkg::DATA_W'(got), '0);
      end else begin
        want = predicted_views.pop_front();
        if (got.top !== want.top) report_mismatch("top_value", got.top, want.top);
        if (got.depth !== want.depth) begin
          report_mismatch("depth", pesev_pkg::DATA_W'(got.depth),
                          pesev_pkg::DATA_W'(want.depth));
        end
        if (got.status !== want.status) begin
          report_mismatch("status", pesev_pkg::DATA_W'(got.status),
                          pesev_pkg::DATA_W'(want.status));
        end
        if (want.status <= pesev_pkg::ST_DIVZERO) status_hits[want.status]++;
      end
      views_checked++;
    end
    if (rst_n && in_tvalid && in_tready) begin
      predicted_views.push_back(apply_symbol(in_tuser[0], in_tdata));
      chars_in++;
    end
  end

  // Long hold-off on the result side so the block backs up and stalls its input.
  initial begin
    while (chars_in < 120) @(posedge clk);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (400) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAIL prefix_expression_stack_evaluator_unit");
    $finish;
  end

  initial begin
    int kind;
    gen_calm = 1'b0;
    // Opening: divide by zero keeps both operands, underflow, bad characters
    // at the ends of the byte range, signed truncation, start on odd symbols.
    queue_char(1'b1, pesev_pkg::CH_ZERO);
    queue_char(1'b0, pesev_pkg::CH_NINE);
    queue_char(1'b0, pesev_pkg::CH_SLASH);
    queue_char(1'b0, pesev_pkg::CH_MINUS);
    queue_char(1'b0, pesev_pkg::CH_PLUS);
    queue_char(1'b0, 8'h00);
    queue_char(1'b0, 8'hFF);
    queue_char(1'b0, 8'h3A);
    queue_char(1'b0, 8'h2E);
    queue_char(1'b0, 8'h80);
    queue_char(1'b0, pesev_pkg::CH_ZERO + 8'd2);
    queue_char(1'b0, pesev_pkg::CH_STAR);
    queue_char(1'b0, pesev_pkg::CH_ZERO + 8'd2);
    queue_char(1'b0, pesev_pkg::CH_ZERO + 8'd7);
    queue_char(1'b0, pesev_pkg::CH_ZERO);
    queue_char(1'b0, pesev_pkg::CH_MINUS);
    queue_char(1'b0, pesev_pkg::CH_SLASH);
    queue_char(1'b0, pesev_pkg::CH_PLUS);
    queue_char(1'b1, pesev_pkg::CH_STAR);
    queue_char(1'b1, pesev_pkg::CH_ZERO + 8'd5);
    queue_char(1'b1, 8'h41);

    // Fill the stack to the brim, push past it, then fold it back down.
    queue_char(1'b1, rand_digit());
    repeat (pesev_pkg::STACK_DEPTH + 1) queue_char(1'b0, rand_digit());
    repeat (pesev_pkg::STACK_DEPTH - 1) queue_char(1'b0, rand_operator());

    // Build -1 under the most negative value, then divide: the quotient wraps.
    queue_char(1'b1, pesev_pkg::CH_ZERO + 8'd1);
    queue_char(1'b0, pesev_pkg::CH_ZERO);
    queue_char(1'b0, pesev_pkg::CH_MINUS);
    queue_char(1'b0, pesev_pkg::CH_ZERO + 8'd2);
    repeat (10) begin
      queue_char(1'b0, pesev_pkg::CH_ZERO + 8'd8);
      queue_char(1'b0, pesev_pkg::CH_STAR);
    end
    queue_char(1'b0, pesev_pkg::CH_SLASH);

    while (char_queue.size() < 950) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        queue_expression($urandom_range(2, 8), $urandom_range(1, 12), 1'b0);
      end else if (kind < 15) begin
        queue_expression($urandom_range(20, 34), $urandom_range(20, 40), 1'b0);
      end else if (kind < 17) begin
        queue_expression($urandom_range(2, 8), $urandom_range(1, 10), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) queue_noise();
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_tvalid || predicted_views.size() != 0) begin
      @(negedge clk);
    end
    repeat (60) @(posedge clk);

    $display("Covered %0d characters and %0d checked results,", chars_in, views_checked);
    $display("through a full stack and a long hold-off. Statuses seen: ok %0d, bad char %0d,",
             status_hits[pesev_pkg::ST_OK], status_hits[pesev_pkg::ST_BADCHAR]);
    $display("underflow %0d, overflow %0d, divide by zero %0d.",
             status_hits[pesev_pkg::ST_UNDER], status_hits[pesev_pkg::ST_OVER],
             status_hits[pesev_pkg::ST_DIVZERO]);
    if (err_count == 0 && predicted_views.size() == 0) begin
      $display("PASS prefix_expression_stack_evaluator_unit");
    end else begin
      $display("FAIL prefix_expression_stack_evaluator_unit");
    end
    $finish;
  end

endmodule

// ===== prefix_expression_stack_evaluator_unit.f =====
design/pesev_pkg.sv
design/pesev_ram.sv
design/pesev_div.sv
design/prefix_expression_stack_evaluator_unit.sv
tb/tb.sv
